// ===== rtl/sls_pkg.sv =====
// Shared types, sizes and helpers of the senescence litter sweep.
// Used by every module and interface in this folder; depends on nothing.
package sls_pkg;

	localparam int HISTORY_DAYS = 512;
	localparam int PART_COUNT   = 7;
	localparam int FIELD_PARTS  = 7;
	localparam int ACTIVE_PARTS = (PART_COUNT < FIELD_PARTS) ? PART_COUNT : FIELD_PARTS;

	localparam int TT_W      = 24;
	localparam int MASS_W    = 24;
	localparam int LIT_W     = 32;
	localparam int SLOT_W    = $clog2(HISTORY_DAYS);
	localparam int PEND_W    = $clog2(HISTORY_DAYS + 1);
	localparam int PART_W    = (ACTIVE_PARTS > 1) ? $clog2(ACTIVE_PARTS) : 1;
	localparam int CFG_IDX_W = $clog2(FIELD_PARTS + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [PART_W-1:0] part_t;

	// Write side of the history store: one day slot, thermal time and one part's mass.
	typedef struct packed {
		logic              tt_we;
		logic              mass_we;
		part_t             part;
		slot_t             slot;
		logic [TT_W-1:0]   tt;
		logic [MASS_W-1:0] mass;
	} hist_wr_t;

	typedef struct packed {
		logic  en;
		part_t part;
		slot_t slot;
	} hist_rd_t;

	function automatic slot_t next_slot(input slot_t s);
		next_slot = (s == SLOT_W'(HISTORY_DAYS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

// ===== rtl/sls_day_if.sv =====
// Input channel of the sweep: one simulated day per word.
// Depends on sls_pkg for the field widths.
interface sls_day_if import sls_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [TT_W-1:0]   day_thermal_time;
	logic [MASS_W-1:0] added_leaf;
	logic [MASS_W-1:0] added_stem;
	logic [MASS_W-1:0] added_flower;
	logic [MASS_W-1:0] added_grain;
	logic [MASS_W-1:0] added_root;
	logic [MASS_W-1:0] added_rhizome;
	logic [MASS_W-1:0] added_nodule;

	modport source (
		output valid, day_thermal_time, added_leaf, added_stem, added_flower,
		       added_grain, added_root, added_rhizome, added_nodule,
		input  ready
	);
	modport sink (
		input  valid, day_thermal_time, added_leaf, added_stem, added_flower,
		       added_grain, added_root, added_rhizome, added_nodule,
		output ready
	);
endinterface

// ===== rtl/sls_litter_if.sv =====
// Output channel of the sweep: the litter of one day per word.
// Depends on sls_pkg for the field widths.
interface sls_litter_if import sls_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [LIT_W-1:0] litter_leaf;
	logic [LIT_W-1:0] litter_stem;
	logic [LIT_W-1:0] litter_flower;
	logic [LIT_W-1:0] litter_grain;
	logic [LIT_W-1:0] litter_root;
	logic [LIT_W-1:0] litter_rhizome;
	logic [LIT_W-1:0] litter_nodule;
	logic             history_overflow;

	modport source (
		output valid, litter_leaf, litter_stem, litter_flower, litter_grain,
		       litter_root, litter_rhizome, litter_nodule, history_overflow,
		input  ready
	);
	modport sink (
		input  valid, litter_leaf, litter_stem, litter_flower, litter_grain,
		       litter_root, litter_rhizome, litter_nodule, history_overflow,
		output ready
	);
endinterface

// ===== rtl/sls_history.sv =====
// History ring of the sweep: thermal time per day and biomass per part and day.
// One write and one registered read per cycle; depends on sls_pkg.
module sls_history import sls_pkg::*; (
	input  logic              clk,
	input  hist_wr_t          wr,
	input  hist_rd_t          rd,
	output logic [TT_W-1:0]   rd_tt,
	output logic [MASS_W-1:0] rd_mass
);

	logic [TT_W-1:0]   tt_mem   [HISTORY_DAYS];
	logic [MASS_W-1:0] mass_mem [ACTIVE_PARTS][HISTORY_DAYS];

	always_ff @(posedge clk) begin
		if (wr.tt_we) begin
			tt_mem[wr.slot] <= wr.tt;
		end
		if (wr.mass_we) begin
			mass_mem[wr.part][wr.slot] <= wr.mass;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_tt   <= tt_mem[rd.slot];
			rd_mass <= mass_mem[rd.part][rd.slot];
		end
	end

endmodule

// ===== rtl/sls_sweep_ctrl.sv =====
// Sequencer of the sweep: thresholds, per-part pointers, the shared compare
// and saturating adder, and the output register. Depends on sls_pkg and drives sls_history.
module sls_sweep_ctrl import sls_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TT_W-1:0]      cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TT_W-1:0]      in_tt,
	input  logic [MASS_W-1:0]    in_added [FIELD_PARTS],
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LIT_W-1:0]     out_litter [FIELD_PARTS],
	output logic                 out_overflow,
	output hist_wr_t             hist_wr,
	output hist_rd_t             hist_rd,
	input  logic [TT_W-1:0]      hist_tt,
	input  logic [MASS_W-1:0]    hist_mass
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WRITE = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_NEXT  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]        state_q;
	part_t             part_q;
	slot_t             cur_q;
	slot_t             slot_q;
	logic [PEND_W-1:0] pend_w_q;
	logic [PEND_W-1:0] pend_q   [ACTIVE_PARTS];
	slot_t             oldest_q [ACTIVE_PARTS];
	logic [TT_W-1:0]   thr_q    [FIELD_PARTS];
	logic              out_vld_q;

	logic [TT_W-1:0]   tt_now_q;
	logic [MASS_W-1:0] added_q [ACTIVE_PARTS];
	logic [LIT_W-1:0]  sum_q;
	logic [LIT_W-1:0]  res_q [ACTIVE_PARTS];
	logic [LIT_W-1:0]  out_litter_q [FIELD_PARTS];
	logic              ovf_q;

	logic [ACTIVE_PARTS-1:0] full;
	logic                    accept;
	logic                    last_part;
	logic                    load_out;
	logic [TT_W:0]           diff;
	logic                    pass;
	logic [LIT_W:0]          add;
	logic [LIT_W-1:0]        sum_next;

	always_comb begin
		for (int p = 0; p < ACTIVE_PARTS; p++) begin
			full[p] = (pend_q[p] >= PEND_W'(HISTORY_DAYS));
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_part = (part_q == PART_W'(ACTIVE_PARTS - 1));
	assign load_out  = (state_q == S_DONE) && (!out_vld_q || out_ready);

	// A day is passed when its elapsed thermal time is not negative and reaches the threshold.
	assign diff     = {1'b0, tt_now_q} - {1'b0, hist_tt};
	assign pass     = !diff[TT_W] && (diff[TT_W-1:0] >= thr_q[part_q]);
	assign add      = {1'b0, sum_q} + (LIT_W + 1)'(hist_mass);
	assign sum_next = add[LIT_W] ? '1 : add[LIT_W-1:0];

	always_comb begin
		hist_wr.tt_we   = (state_q == S_WRITE) && (part_q == '0);
		hist_wr.mass_we = (state_q == S_WRITE);
		hist_wr.part    = part_q;
		hist_wr.slot    = cur_q;
		hist_wr.tt      = tt_now_q;
		hist_wr.mass    = added_q[part_q];
		hist_rd.en      = (state_q == S_READ) && (pend_w_q > PEND_W'(1));
		hist_rd.part    = part_q;
		hist_rd.slot    = slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			part_q    <= '0;
			cur_q     <= '0;
			slot_q    <= '0;
			pend_w_q  <= '0;
			out_vld_q <= 1'b0;
			for (int p = 0; p < ACTIVE_PARTS; p++) begin
				pend_q[p]   <= '0;
				oldest_q[p] <= '0;
			end
			for (int p = 0; p < FIELD_PARTS; p++) begin
				thr_q[p] <= '0;
			end
		end else begin
			if (cfg_we && (cfg_index < CFG_IDX_W'(FIELD_PARTS))) begin
				thr_q[cfg_index[CFG_IDX_W-1:0]] <= cfg_data;
			end

			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// A full part drops its oldest day before the new one goes in.
						for (int p = 0; p < ACTIVE_PARTS; p++) begin
							if (full[p]) begin
								oldest_q[p] <= next_slot(oldest_q[p]);
							end
							pend_q[p] <= (full[p] ? PEND_W'(HISTORY_DAYS - 1) : pend_q[p])
							             + 1'b1;
						end
						part_q  <= '0;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (last_part) begin
						part_q  <= '0;
						cur_q   <= next_slot(cur_q);
						state_q <= S_LOAD;
					end else begin
						part_q <= part_q + 1'b1;
					end
				end
				S_LOAD: begin
					slot_q   <= oldest_q[part_q];
					pend_w_q <= pend_q[part_q];
					state_q  <= S_READ;
				end
				S_READ: begin
					// The current day is never passed, so at least one day stays pending.
					state_q <= (pend_w_q > PEND_W'(1)) ? S_CMP : S_NEXT;
				end
				S_CMP: begin
					if (pass) begin
						slot_q   <= next_slot(slot_q);
						pend_w_q <= pend_w_q - 1'b1;
						state_q  <= S_READ;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					oldest_q[part_q] <= slot_q;
					pend_q[part_q]   <= pend_w_q;
					if (last_part) begin
						state_q <= S_DONE;
					end else begin
						part_q  <= part_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tt_now_q <= in_tt;
			ovf_q    <= |full;
			for (int p = 0; p < ACTIVE_PARTS; p++) begin
				added_q[p] <= in_added[p];
			end
		end
		if (state_q == S_LOAD) begin
			sum_q <= '0;
		end else if ((state_q == S_CMP) && pass) begin
			sum_q <= sum_next;
		end
		if (state_q == S_NEXT) begin
			res_q[part_q] <= sum_q;
		end
		if (load_out) begin
			out_overflow <= ovf_q;
			for (int p = 0; p < ACTIVE_PARTS; p++) begin
				out_litter_q[p] <= res_q[p];
			end
			for (int p = ACTIVE_PARTS; p < FIELD_PARTS; p++) begin
				out_litter_q[p] <= '0;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign out_litter = out_litter_q;

endmodule

// ===== rtl/senescence_litter_sweep.sv =====
// Top level of the senescence litter sweep.
// Depends on sls_pkg, sls_day_if, sls_litter_if, sls_history and sls_sweep_ctrl.
//
// Each accepted day word is stored in a history ring, then every plant part's
// oldest-unsenesced pointer walks forward over earlier days whose elapsed
// thermal time reaches that part's threshold, and the biomass passed is summed
// (saturating) into the day's litter. The block takes one day at a time. After
// the accept step, the masses of the 7 parts are written in turn; then each part's
// walk loads its pointer and reads and compares one earlier pending day after
// another, until a day falls short or only the current day is left, and then
// stores the part's result. Last comes the hand-off to the output register.
// The pace is set by the single read port of the history ring and the read
// and compare step of the shared walk unit. A finished result waits in an
// output register, so the next day is taken while it waits to be read. The
// hand-off stalls only while the previous word is still unread. No clearing
// pass is needed after reset.
module senescence_litter_sweep import sls_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TT_W-1:0]      cfg_data,
	sls_day_if.sink              day,
	sls_litter_if.source         litter
);

	logic [MASS_W-1:0] added [FIELD_PARTS];
	logic [LIT_W-1:0]  lit   [FIELD_PARTS];
	hist_wr_t          hist_wr;
	hist_rd_t          hist_rd;
	logic [TT_W-1:0]   hist_tt;
	logic [MASS_W-1:0] hist_mass;

	assign added[0] = day.added_leaf;
	assign added[1] = day.added_stem;
	assign added[2] = day.added_flower;
	assign added[3] = day.added_grain;
	assign added[4] = day.added_root;
	assign added[5] = day.added_rhizome;
	assign added[6] = day.added_nodule;

	sls_history u_history (
		.clk     (clk),
		.wr      (hist_wr),
		.rd      (hist_rd),
		.rd_tt   (hist_tt),
		.rd_mass (hist_mass)
	);

	sls_sweep_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (day.valid),
		.in_ready     (day.ready),
		.in_tt        (day.day_thermal_time),
		.in_added     (added),
		.out_valid    (litter.valid),
		.out_ready    (litter.ready),
		.out_litter   (lit),
		.out_overflow (litter.history_overflow),
		.hist_wr      (hist_wr),
		.hist_rd      (hist_rd),
		.hist_tt      (hist_tt),
		.hist_mass    (hist_mass)
	);

	assign litter.litter_leaf    = lit[0];
	assign litter.litter_stem    = lit[1];
	assign litter.litter_flower  = lit[2];
	assign litter.litter_grain   = lit[3];
	assign litter.litter_root    = lit[4];
	assign litter.litter_rhizome = lit[5];
	assign litter.litter_nodule  = lit[6];

endmodule
